// File: sv/dxt_pkg.sv
// Shared types, format codes and fixed-point helpers of the DXT block decoder.
package dxt_pkg;

  // Format codes of the format_mode register.
  localparam logic [1:0] FMT_DXT1     = 2'd0;
  localparam logic [1:0] FMT_EXPLICIT = 2'd1;
  localparam logic [1:0] FMT_INTERP   = 2'd2;
  localparam logic [1:0] FMT_RESERVED = 2'd3;

  localparam int unsigned TEXELS = 16;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // Classified block as it waits between the front and the back end.
  typedef struct packed {
    logic [1:0]  mode;
    logic        three_colour;
    logic        alpha_wide;
    rgb_t        c0;
    rgb_t        c1;
    logic [31:0] colour_idx;
    logic [63:0] alpha_block;
  } block_desc_t;

  // Widen an RGB565 endpoint to 8 bits per channel by bit replication.
  function automatic rgb_t widen565(input logic [15:0] c);
    rgb_t w;
    w.r = {c[15:11], c[15:13]};
    w.g = {c[10:5], c[10:9]};
    w.b = {c[4:0], c[4:2]};
    return w;
  endfunction

  // Exact floor(x / 3) for x below 768, by reciprocal multiplication.
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd683;
    return p[18:11];
  endfunction

  // Exact floor(x / 5) for x below 1280.
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd1639;
    return p[20:13];
  endfunction

  // Exact floor(x / 7) for x below 1792.
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd2341;
    return p[21:14];
  endfunction

endpackage

// File: sv/dxt_if.sv
// Handshake channel interfaces: configuration writes, compressed blocks, decoded texels.

interface dxt_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dxt_blk_if;
  logic        valid;
  logic        ready;
  logic [63:0] colour_block;
  logic [63:0] alpha_block;
  modport source (output valid, output colour_block, output alpha_block, input ready);
  modport sink (input valid, input colour_block, input alpha_block, output ready);
endinterface

interface dxt_texel_if;
  logic       valid;
  logic       ready;
  logic [3:0] texel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       last_texel;
  modport source (output valid, output texel_index, output red, output green,
                  output blue, output alpha, output last_texel, input ready);
  modport sink (input valid, input texel_index, input red, input green,
                input blue, input alpha, input last_texel, output ready);
endinterface

// File: sv/dxt_front.sv
// Front end: holds the format register, accepts blocks and classifies them.
module dxt_front (
  input  logic                 clk,
  input  logic                 rst,
  dxt_cfg_if.sink              cfg,
  dxt_blk_if.sink              blocks,
  output logic                 push_valid,
  input  logic                 push_ready,
  output dxt_pkg::block_desc_t push_data
);

  logic [1:0]  format_mode;
  logic [15:0] e0;
  logic [15:0] e1;

  // Configuration writes are always taken; the unused code is dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode <= dxt_pkg::FMT_DXT1;
    end else if (cfg.valid && cfg.data != dxt_pkg::FMT_RESERVED) begin
      format_mode <= cfg.data;
    end
  end

  // A block beat passes straight into the queue when it has room.
  assign blocks.ready = push_ready;
  assign push_valid   = blocks.valid;

  assign e0 = blocks.colour_block[15:0];
  assign e1 = blocks.colour_block[31:16];

  // Classify the block: palette flavor, alpha ramp flavor, widened endpoints.
  always_comb begin
    push_data.mode         = format_mode;
    push_data.three_colour = (format_mode == dxt_pkg::FMT_DXT1) && (e0 <= e1);
    push_data.alpha_wide   = blocks.alpha_block[7:0] > blocks.alpha_block[15:8];
    push_data.c0           = dxt_pkg::widen565(e0);
    push_data.c1           = dxt_pkg::widen565(e1);
    push_data.colour_idx   = blocks.colour_block[63:32];
    push_data.alpha_block  = blocks.alpha_block;
  end

endmodule

// File: sv/dxt_queue.sv
// Short queue of classified blocks between the front and the back end.
module dxt_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  dxt_pkg::block_desc_t push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output dxt_pkg::block_desc_t pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  dxt_pkg::block_desc_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Slot storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // The fill count never passes the depth.
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

// File: sv/dxt_back.sv
// Back end: walks the sixteen texels of a block through a two-stage datapath.
module dxt_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  dxt_pkg::block_desc_t pop_data,
  dxt_texel_if.source          texels
);

  // How the second stage finishes a channel.
  localparam logic [1:0] FIN_PASS  = 2'd0;
  localparam logic [1:0] FIN_FIFTH = 2'd2;
  localparam logic [1:0] FIN_SEVTH = 2'd3;

  typedef struct packed {
    logic       third;
    logic [9:0] num;
  } chan_num_t;

  dxt_pkg::block_desc_t cur;
  logic                 cur_valid;
  logic [3:0]           cnt;
  logic                 adv;
  logic                 last_issue;

  logic [1:0]  ci;
  logic [2:0]  aj;
  logic [2:0]  ak;
  logic [3:0]  nib;
  logic [7:0]  a0;
  logic [7:0]  a1;
  logic [5:0]  a_off;
  chan_num_t   r_num;
  chan_num_t   g_num;
  chan_num_t   b_num;
  logic [10:0] a_num;
  logic [1:0]  a_fin;

  logic        s1_valid;
  logic [3:0]  s1_idx;
  logic        s1_last;
  chan_num_t   s1_r;
  chan_num_t   s1_g;
  chan_num_t   s1_b;
  logic [10:0] s1_a;
  logic [1:0]  s1_a_fin;

  logic        out_valid;

  // Palette entry numerator of one colour channel for index sel.
  function automatic chan_num_t col_num(input logic [7:0] c0, input logic [7:0] c1,
                                        input logic [1:0] sel, input logic three);
    chan_num_t n;
    logic [8:0] half_sum;
    half_sum = 9'(c0) + 9'(c1) + 9'd1;
    n.third  = 1'b0;
    n.num    = 10'(c0);
    case (sel)
      2'd0: n.num = 10'(c0);
      2'd1: n.num = 10'(c1);
      2'd2: begin
        if (three) begin
          n.num = 10'(half_sum[8:1]);
        end else begin
          n.third = 1'b1;
          n.num   = {1'b0, c0, 1'b0} + 10'(c1) + 10'd1;
        end
      end
      default: begin
        if (three) begin
          n.num = '0;
        end else begin
          n.third = 1'b1;
          n.num   = 10'(c0) + {1'b0, c1, 1'b0} + 10'd1;
        end
      end
    endcase
    return n;
  endfunction

  // The whole datapath moves when the output register is free or drained.
  assign adv        = !out_valid || texels.ready;
  assign last_issue = cur_valid && adv && (cnt == 4'(dxt_pkg::TEXELS - 1));
  assign pop_ready  = !cur_valid || last_issue;

  // Current block and texel counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (cur_valid && adv) begin
        cnt <= cnt + 1'b1;
      end
      if (pop_valid && pop_ready) begin
        cur_valid <= 1'b1;
      end else if (last_issue) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur <= pop_data;
    end
  end

  // Stage one: pick the palette entries and form their numerators.
  always_comb begin
    ci    = cur.colour_idx[{cnt, 1'b0} +: 2];
    a_off = 6'd16 + 6'(cnt) * 6'd3;
    aj    = cur.alpha_block[a_off +: 3];
    ak    = aj - 3'd1;
    nib   = cur.alpha_block[{cnt, 2'b00} +: 4];
    a0    = cur.alpha_block[7:0];
    a1    = cur.alpha_block[15:8];
    r_num = col_num(cur.c0.r, cur.c1.r, ci, cur.three_colour);
    g_num = col_num(cur.c0.g, cur.c1.g, ci, cur.three_colour);
    b_num = col_num(cur.c0.b, cur.c1.b, ci, cur.three_colour);
    a_fin = FIN_PASS;
    a_num = 11'd255;
    case (cur.mode)
      dxt_pkg::FMT_EXPLICIT: a_num = 11'({nib, nib});
      dxt_pkg::FMT_INTERP: begin
        if (aj == 3'd0) begin
          a_num = 11'(a0);
        end else if (aj == 3'd1) begin
          a_num = 11'(a1);
        end else if (cur.alpha_wide) begin
          a_fin = FIN_SEVTH;
          a_num = 11'(3'd7 - ak) * 11'(a0) + 11'(ak) * 11'(a1) + 11'd3;
        end else if (aj == 3'd6) begin
          a_num = '0;
        end else if (aj == 3'd7) begin
          a_num = 11'd255;
        end else begin
          a_fin = FIN_FIFTH;
          a_num = 11'(3'd5 - ak) * 11'(a0) + 11'(ak) * 11'(a1) + 11'd2;
        end
      end
      default: a_num = (cur.three_colour && ci == 2'd3) ? 11'd0 : 11'd255;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx   <= cnt;
      s1_last  <= cnt == 4'(dxt_pkg::TEXELS - 1);
      s1_r     <= r_num;
      s1_g     <= g_num;
      s1_b     <= b_num;
      s1_a     <= a_num;
      s1_a_fin <= a_fin;
    end
  end

  // Stage two: constant divisions into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      texels.texel_index <= s1_idx;
      texels.last_texel  <= s1_last;
      texels.red   <= s1_r.third ? dxt_pkg::div3(s1_r.num) : s1_r.num[7:0];
      texels.green <= s1_g.third ? dxt_pkg::div3(s1_g.num) : s1_g.num[7:0];
      texels.blue  <= s1_b.third ? dxt_pkg::div3(s1_b.num) : s1_b.num[7:0];
      case (s1_a_fin)
        FIN_SEVTH: texels.alpha <= dxt_pkg::div7(s1_a);
        FIN_FIFTH: texels.alpha <= dxt_pkg::div5(s1_a);
        default:   texels.alpha <= s1_a[7:0];
      endcase
    end
  end

  assign texels.valid = out_valid;

  // The last flag of an output beat belongs to the final texel position.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && texels.last_texel |-> texels.texel_index == 4'(dxt_pkg::TEXELS - 1))
    else $error("last texel flag on wrong position");

  // With no block in hand the counter rests at the first texel.
  assert property (@(posedge clk) disable iff (rst) !cur_valid |-> cnt == 4'd0)
    else $error("texel counter moved without a block");

  // A stalled output holds the texel counter still.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !texels.ready |=> cnt == $past(cnt))
    else $error("texel counter advanced under stall");

endmodule

// File: sv/dxt_texture_block_decoder.sv
// Top level of the DXT texture block decoder: front end, block queue and back end.
//
//   channel   dir   beat                                    
//   cfg       in    one format_mode write (2 bits)          
//   blocks    in    colour_block and alpha_block, 64 each   
//   texels    out   one RGBA8 texel with index and last flag
//
// Each block gives sixteen texel beats, one per cycle while texels is ready;
// the texel counter in the back end steps through the sixteen positions.
// Registers on a texel's way: queue slot, current block, stage one, output.
// The block queue holds QUEUE_DEPTH classified blocks, so blocks are taken while
// texels of earlier ones still wait; a stall on texels freezes the back end only.
// Reset clears the format to DXT1 and empties the queue and the pipeline.
module dxt_texture_block_decoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input logic         clk,
  input logic         rst,
  dxt_cfg_if.sink     cfg,
  dxt_blk_if.sink     blocks,
  dxt_texel_if.source texels
);

  logic                 push_valid;
  logic                 push_ready;
  dxt_pkg::block_desc_t push_data;
  logic                 pop_valid;
  logic                 pop_ready;
  dxt_pkg::block_desc_t pop_data;

  dxt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .blocks     (blocks),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  dxt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  dxt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .texels    (texels)
  );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench of the DXT texture block decoder: texel scoreboard and block drivers.

// One decoded texel as it leaves the decoder.
typedef struct packed {
  logic [3:0] idx;
  logic [7:0] r;
  logic [7:0] g;
  logic [7:0] b;
  logic [7:0] a;
  logic       is_last;
} texel_t;

// Predicts the sixteen texels of each accepted block and checks the texel beats.
class texel_scoreboard;
  logic [1:0]  fmt;
  texel_t      expected_q[$];
  int unsigned errors;

  function new();
    fmt = dxt_pkg::FMT_DXT1;
    errors = 0;
  endfunction

  // The reserved format code leaves the register unchanged.
  function void write_format(logic [1:0] v);
    if (v != dxt_pkg::FMT_RESERVED) fmt = v;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  // Decode one compressed block into its sixteen expected texels.
  function void note_block(logic [63:0] cb, logic [63:0] ab);
    int unsigned ends[2][3];
    int unsigned pal[4][4];
    int unsigned apal[8];
    int unsigned a0, a1, ci, av, f;
    logic [15:0] ep;
    bit          three;
    texel_t      t;
    // Widen both RGB565 endpoints by repeating their top bits.
    for (int e = 0; e < 2; e++) begin
      ep = cb[16*e +: 16];
      f = ep[15:11];
      ends[e][0] = (f << 3) | (f >> 2);
      f = ep[10:5];
      ends[e][1] = (f << 2) | (f >> 4);
      f = ep[4:0];
      ends[e][2] = (f << 3) | (f >> 2);
    end
    // Colour palette: three colours plus transparent black only in DXT1 with e0 <= e1.
    three = (fmt == dxt_pkg::FMT_DXT1) && (cb[15:0] <= cb[31:16]);
    for (int ch = 0; ch < 3; ch++) begin
      pal[0][ch] = ends[0][ch];
      pal[1][ch] = ends[1][ch];
      if (three) begin
        pal[2][ch] = (ends[0][ch] + ends[1][ch] + 1) / 2;
        pal[3][ch] = 0;
      end else begin
        pal[2][ch] = (2 * ends[0][ch] + ends[1][ch] + 1) / 3;
        pal[3][ch] = (ends[0][ch] + 2 * ends[1][ch] + 1) / 3;
      end
    end
    pal[0][3] = 255;
    pal[1][3] = 255;
    pal[2][3] = 255;
    pal[3][3] = three ? 0 : 255;
    // Interpolated alpha palette: eight entries, or six plus fixed 0 and 255.
    a0 = ab[7:0];
    a1 = ab[15:8];
    apal[0] = a0;
    apal[1] = a1;
    if (a0 > a1) begin
      for (int k = 1; k <= 6; k++) apal[k + 1] = ((7 - k) * a0 + k * a1 + 3) / 7;
    end else begin
      for (int k = 1; k <= 4; k++) apal[k + 1] = ((5 - k) * a0 + k * a1 + 2) / 5;
      apal[6] = 0;
      apal[7] = 255;
    end
    // Texels in row order.
    for (int i = 0; i < 16; i++) begin
      ci = cb[32 + 2 * i +: 2];
      case (fmt)
        dxt_pkg::FMT_EXPLICIT: av = int'(ab[4 * i +: 4]) * 17;
        dxt_pkg::FMT_INTERP: av = apal[ab[16 + 3 * i +: 3]];
        default: av = pal[ci][3];
      endcase
      t.idx = 4'(i);
      t.r = 8'(pal[ci][0]);
      t.g = 8'(pal[ci][1]);
      t.b = 8'(pal[ci][2]);
      t.a = 8'(av);
      t.is_last = (i == 15);
      expected_q.push_back(t);
    end
  endfunction

  // Compare one texel beat with the oldest expected texel.
  function void check_texel(texel_t got);
    texel_t want;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("ERROR: texel %0d arrived with nothing expected", got.idx);
      return;
    end
    want = expected_q.pop_front();
    if (got.idx !== want.idx || got.r !== want.r || got.g !== want.g || got.b !== want.b ||
        got.a !== want.a || got.is_last !== want.is_last) begin
      errors++;
      if (errors <= 10) begin
        $display("ERROR: texel mismatch, expected idx %0d rgba %h %h %h %h last %b",
                 want.idx, want.r, want.g, want.b, want.a, want.is_last);
        $display("       got                 idx %0d rgba %h %h %h %h last %b",
                 got.idx, got.r, got.g, got.b, got.a, got.is_last);
      end
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 500;

  logic clk;
  logic rst;
  bit   blk_idle_on;
  bit   tex_idle_on;

  dxt_cfg_if   cfg_ch ();
  dxt_blk_if   blk_ch ();
  dxt_texel_if tex_ch ();

  texel_scoreboard sb = new();

  dxt_texture_block_decoder i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .blocks (blk_ch),
    .texels (tex_ch)
  );

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Texel sink: ready drops in random bursts while idling is on.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    tex_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        tex_ch.ready = 1'b0;
        stall_left--;
      end else begin
        tex_ch.ready = 1'b1;
        if (tex_idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 9);
      end
    end
  end

  // Check every texel beat.
  always @(posedge clk) begin
    texel_t got;
    if (!rst && tex_ch.valid && tex_ch.ready) begin
      got.idx = tex_ch.texel_index;
      got.r = tex_ch.red;
      got.g = tex_ch.green;
      got.b = tex_ch.blue;
      got.a = tex_ch.alpha;
      got.is_last = tex_ch.last_texel;
      sb.check_texel(got);
    end
  end

  // Watchdog: end the run when no beat moves on any channel for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((blk_ch.valid && blk_ch.ready) || (tex_ch.valid && tex_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("ERROR: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Send one block beat, after an optional random gap; valid stays high on return.
  task automatic send_block(input logic [63:0] cb, input logic [63:0] ab);
    int unsigned gap;
    gap = (blk_idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
    repeat (gap) begin
      @(negedge clk);
      blk_ch.valid = 1'b0;
    end
    @(negedge clk);
    blk_ch.valid = 1'b1;
    blk_ch.colour_block = cb;
    blk_ch.alpha_block = ab;
    @(posedge clk);
    while (!blk_ch.ready) @(posedge clk);
    sb.note_block(cb, ab);
  endtask

  // Write the format register once the decoder has drained all its texels.
  task automatic write_format(input logic [1:0] v);
    @(negedge clk);
    blk_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.data = v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_format(v);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Stimulus: directed blocks per format, then random phases with varying formats.
  initial begin
    logic [63:0] cb;
    logic [63:0] ab;
    logic [1:0]  phase_fmt[8];
    phase_fmt = '{dxt_pkg::FMT_INTERP, dxt_pkg::FMT_DXT1, dxt_pkg::FMT_RESERVED,
                  dxt_pkg::FMT_EXPLICIT, dxt_pkg::FMT_DXT1, dxt_pkg::FMT_INTERP,
                  dxt_pkg::FMT_EXPLICIT, dxt_pkg::FMT_DXT1};
    rst = 1'b1;
    blk_idle_on = 1'b0;
    tex_idle_on = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = dxt_pkg::FMT_DXT1;
    blk_ch.valid = 1'b0;
    blk_ch.colour_block = '0;
    blk_ch.alpha_block = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    blk_idle_on = 1'b1;
    tex_idle_on = 1'b1;

    // DXT1 from reset: four-colour, three-colour, equal endpoints, all zeros and ones.
    send_block(64'hE4E4E4E4_0000_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block(64'hE4E4E4E4_FFFF_0000, 64'h0);
    send_block(64'hE4E4E4E4_1234_1234, 64'h0123_4567_89AB_CDEF);
    send_block(64'h0, 64'h0);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block(64'hE4E4E4E4_F81F_07E0, 64'h0);
    send_block(64'h1B1B1B1B_07E0_F81F, 64'h0);

    // Explicit alpha, four colours even with e0 <= e1.
    write_format(dxt_pkg::FMT_EXPLICIT);
    send_block(64'hE4E4E4E4_0000_FFFF, 64'hFEDC_BA98_7654_3210);
    send_block(64'hE4E4E4E4_FFFF_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block({$urandom, $urandom}, 64'h0);

    // Interpolated alpha: a0 above, below and equal to a1, every index used.
    write_format(dxt_pkg::FMT_INTERP);
    send_block(64'hE4E4E4E4_0000_FFFF, 64'hFAC6_88FA_C688_00FF);
    send_block(64'hE4E4E4E4_FFFF_0000, 64'hFAC6_88FA_C688_FF00);
    send_block(64'hE4E4E4E4_1234_1234, 64'hFAC6_88FA_C688_8080);
    send_block(64'h4E4E4E4E_07E0_F81F, 64'hFAC6_88FA_C688_3AC5);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);

    // The reserved code must leave interpolated alpha in place.
    write_format(dxt_pkg::FMT_RESERVED);
    send_block(64'hE4E4E4E4_F81F_07E0, 64'hFAC6_88FA_C688_10F0);

    // Back to DXT1 with a three-colour block.
    write_format(dxt_pkg::FMT_DXT1);
    send_block(64'hE4E4E4E4_F81F_07E0, 64'hFAC6_88FA_C688_10F0);

    // Random phases; the last one runs without idling on either side.
    for (int p = 0; p < 8; p++) begin
      write_format(phase_fmt[p]);
      blk_idle_on = (p < 7) && ($urandom_range(0, 3) != 0);
      tex_idle_on = (p < 7) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 45; n++) begin
        cb = {$urandom, $urandom};
        ab = {$urandom, $urandom};
        case ($urandom_range(0, 7))
          0: cb[31:16] = cb[15:0];
          1: ab[15:8] = ab[7:0];
          2: cb[63:32] = '1;
          default: ;
        endcase
        send_block(cb, ab);
      end
    end

    // Drain the remaining texels, then wait for stray beats.
    @(negedge clk);
    blk_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
